/* design/flsa_pkg.sv */
`default_nettype none

package flsa_pkg;

   // default pool geometry
   localparam int FLSA_SLOTS      = 16;
   localparam int FLSA_SLOT_BYTES = 32;

   // fixed field widths
   localparam int ADDR_W       = 64;
   localparam int STATUS_W     = 2;
   localparam int SLOT_INDEX_W = 4;
   localparam int RSP_DATA_W   = 72;

   // request kind carried on tuser
   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_ILLEGAL = 2'd2,
      ST_DOUBLE  = 2'd3
   } status_type;

endpackage

`default_nettype wire

/* design/flsa_ram.sv */
`default_nettype none

module flsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/flsa_addr_dec.sv */
`default_nettype none

module flsa_addr_dec
   import flsa_pkg::*;
#(
   parameter int SLOTS      = FLSA_SLOTS,
   parameter int SLOT_BYTES = FLSA_SLOT_BYTES
) (
   input  wire logic [ADDR_W-1:0]        offset,
   input  wire logic                     below_base,
   output logic                          legal,
   output logic      [$clog2(SLOTS)-1:0] slot_idx
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam longint unsigned TOTAL = 64'(SLOTS) * 64'(SLOT_BYTES);
   localparam int OFF_W = $clog2(TOTAL);
   localparam int DIV_W = $clog2(SLOT_BYTES);
   // reciprocal precision: enough guard bits that the quotient is exact and
   // the low product bits tell a zero remainder apart from any other
   localparam int SH    = OFF_W + DIV_W + 2;
   localparam int M_W   = SH - DIV_W + 2;
   localparam int PROD_W = OFF_W + M_W;
   localparam int LOW_W = SH + 2;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(SLOT_BYTES) - 64'd1) / 64'(SLOT_BYTES);

   logic [PROD_W-1:0] prod;
   logic              in_range;
   logic              exact;

   // offset times reciprocal gives quotient in the high bits
   assign prod     = PROD_W'(offset[OFF_W-1:0]) * PROD_W'(RECIP);
   assign slot_idx = IDX_W'(prod[PROD_W-1:SH]);

   // remainder is zero exactly when the fraction bits stay under the reciprocal
   assign exact    = LOW_W'(prod[SH-1:0]) < LOW_W'(RECIP);
   assign in_range = offset < ADDR_W'(TOTAL);
   assign legal    = !below_base && in_range && exact;

endmodule

`default_nettype wire

/* design/free_list_slot_allocator.sv */
// channel  | dir | handshake            | payload
// req      | in  | req_tvalid/tready    | tuser: cmd, tdata: free_addr
// rsp      | out | rsp_tvalid/tready    | tdata: status, slot_index, slot_addr
// csr      | in  | csr_wr_en            | csr_wr_data: pool_base
//
// a successful allocate holds off the next item while the link of the new head
// slot is read from the link RAM after the pop; a free request or an allocate
// that finds the pool empty holds off nothing
// requests pass an input register, combinational logic and a result register
// reset is synchronous and needs no clearing pass: slots never handed out are
// tracked by a fresh-slot counter, so the link RAM needs no initial contents
// a stalled result holds in its register while the next item is taken in
`default_nettype none

module free_list_slot_allocator
   import flsa_pkg::*;
#(
   parameter int SLOTS      = FLSA_SLOTS,
   parameter int SLOT_BYTES = FLSA_SLOT_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [ADDR_W-1:0]     csr_wr_data,    // pool_base
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [0:0]            req_tuser,      // [0] cmd
   input  wire logic [ADDR_W-1:0]     req_tdata,      // [63:0] free_addr
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata       // [1:0] status, [5:2] slot_index,
                                                      // [69:6] slot_addr, [71:70] zero
);

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam longint unsigned TOTAL = 64'(SLOTS) * 64'(SLOT_BYTES);
   localparam int OFF_W  = $clog2(TOTAL);
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);

   // configuration register
   logic [ADDR_W-1:0] base_ff;

   // input register
   logic              in_vld_ff, in_vld_in;
   cmd_type           in_cmd_ff;
   logic [ADDR_W-1:0] in_off_ff;
   logic              in_below_ff;
   logic [ADDR_W:0]   sub_full;

   // free-list state
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] hnext_ff, hnext_in;
   logic [LINK_W-1:0] fresh_ff, fresh_in;
   logic [SLOTS-1:0]  mark_ff, mark_in;
   logic              refill_ff, refill_in;
   logic              use_ram_ff, use_ram_in;

   // result register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // processing stage
   logic              advance;
   logic              head_empty;
   logic [IDX_W-1:0]  head_idx;
   logic [OFF_W-1:0]  alloc_off;
   logic              dec_legal;
   logic [IDX_W-1:0]  dec_idx;
   status_type        res_status;
   logic [IDX_W-1:0]  res_idx;
   logic [ADDR_W-1:0] res_addr;
   logic              alloc_ok;
   logic              free_ok;
   logic              alloc_fire;
   logic              free_fire;
   logic [LINK_W-1:0] ram_rd_data;

   // handshakes
   assign advance    = in_vld_ff && !refill_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // offset from pool base, formed as the item enters
   assign sub_full = {1'b0, req_tdata} - {1'b0, base_ff};

   flsa_addr_dec #(
      .SLOTS      (SLOTS),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_addr_dec (
      .offset     (in_off_ff),
      .below_base (in_below_ff),
      .legal      (dec_legal),
      .slot_idx   (dec_idx)
   );

   // link RAM: written on free, read for the next link after a pop
   flsa_ram #(
      .WIDTH (LINK_W),
      .DEPTH (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (free_fire),
      .wr_addr (dec_idx),
      .wr_data (head_ff),
      .rd_en   (alloc_fire),
      .rd_addr (hnext_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // request decode and result
   assign head_empty = head_ff == NULL_LINK;
   assign head_idx   = head_ff[IDX_W-1:0];
   assign alloc_off  = OFF_W'(head_idx) * OFF_W'(SLOT_BYTES);

   always_comb begin
      res_status = ST_OK;
      res_idx    = '0;
      res_addr   = '0;
      alloc_ok   = 1'b0;
      free_ok    = 1'b0;
      if (in_cmd_ff == CMD_ALLOC) begin
         if (head_empty) begin
            res_status = ST_EMPTY;
         end else begin
            alloc_ok = 1'b1;
            res_idx  = head_idx;
            res_addr = base_ff + ADDR_W'(alloc_off);
         end
      end else if (!dec_legal) begin
         res_status = ST_ILLEGAL;
      end else if (mark_ff[dec_idx]) begin
         res_status = ST_DOUBLE;
      end else begin
         free_ok = 1'b1;
         res_idx = dec_idx;
      end
   end

   assign alloc_fire = advance && alloc_ok;
   assign free_fire  = advance && free_ok;

   // next state of the free list
   always_comb begin
      head_in    = head_ff;
      hnext_in   = hnext_ff;
      fresh_in   = fresh_ff;
      mark_in    = mark_ff;
      refill_in  = 1'b0;
      use_ram_in = use_ram_ff;
      if (refill_ff) begin
         hnext_in = use_ram_ff ? ram_rd_data : LINK_W'(head_ff + 1'b1);
      end
      if (alloc_fire) begin
         head_in           = hnext_ff;
         mark_in[head_idx] = 1'b0;
         if (head_ff == fresh_ff) begin
            fresh_in = LINK_W'(fresh_ff + 1'b1);
         end
         refill_in  = 1'b1;
         use_ram_in = hnext_ff < fresh_in;
      end
      if (free_fire) begin
         head_in          = LINK_W'(dec_idx);
         hnext_in         = head_ff;
         mark_in[dec_idx] = 1'b1;
      end
   end

   // next state of the input and result registers
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tready) begin
         in_vld_in = req_tvalid;
      end
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = {2'b00, res_addr, SLOT_INDEX_W'(res_idx), res_status};
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         head_ff    <= '0;
         hnext_ff   <= LINK_W'(1);
         fresh_ff   <= '0;
         mark_ff    <= '1;
         refill_ff  <= 1'b0;
         use_ram_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_ff <= csr_wr_data;
         end
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         head_ff    <= head_in;
         hnext_ff   <= hnext_in;
         fresh_ff   <= fresh_in;
         mark_ff    <= mark_in;
         refill_ff  <= refill_in;
         use_ram_ff <= use_ram_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff   <= cmd_type'(req_tuser[0]);
         in_off_ff   <= sub_full[ADDR_W-1:0];
         in_below_ff <= sub_full[ADDR_W];
      end
      rsp_data_ff <= rsp_data_in;
   end

   // the link fetch after a pop ends before another fetch can start
   a_refill_single: assert property (@(posedge clock) disable iff (reset)
      refill_ff |=> !refill_ff)
      else $error("link refill lasted more than one cycle");

   // no item is processed while the head link is being fetched
   a_no_advance_in_refill: assert property (@(posedge clock) disable iff (reset)
      refill_ff |-> !advance)
      else $error("item processed during link refill");

   // head and fresh counter stay within the pool or at the null link
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= NULL_LINK) && (fresh_ff <= NULL_LINK))
      else $error("free-list pointer out of range");

   // a successful pop clears the slot's free mark
   a_alloc_clears_mark: assert property (@(posedge clock) disable iff (reset)
      alloc_fire |=> !mark_ff[$past(head_idx)])
      else $error("allocated slot still marked free");

endmodule

`default_nettype wire
